### rtl/core/lwat_pkg.sv
package lwat_pkg;

    // default sizes of the table
    localparam int NUM_IDS_DEF       = 64;
    localparam int HISTORY_DEPTH_DEF = 16;

    // configuration port
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_THRESHOLD = 1'b0,
        CFG_MAX_OBS   = 1'b1
    } cfg_idx_t;

    localparam logic [15:0] THRESHOLD_RST = 16'd45875;
    localparam logic [4:0]  MAX_OBS_RST   = 5'd10;

    // 1/CORDIC gain, Q0.16
    localparam logic [16:0] INV_GAIN     = 17'd39797;
    localparam int          CORDIC_STEPS = 16;

    typedef struct packed {
        logic        [5:0]  marker_id;
        logic signed [19:0] cam_right;
        logic signed [19:0] cam_away;
        logic signed [19:0] cam_up;
        logic        [15:0] sighting_confidence;
        logic signed [23:0] robot_x;
        logic signed [23:0] robot_y;
        logic signed [23:0] robot_z;
        logic signed [15:0] quat_x;
        logic signed [15:0] quat_y;
        logic signed [15:0] quat_z;
        logic signed [15:0] quat_w;
    } in_t;

    typedef struct packed {
        logic        [5:0]  out_id;
        logic signed [23:0] mean_x;
        logic signed [23:0] mean_y;
        logic signed [23:0] mean_z;
        logic        [15:0] mean_confidence;
        logic        [4:0]  obs_count;
        logic               last_result;
    } out_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL,
        ST_PREP,
        ST_ROT,
        ST_SCALE,
        ST_GLOBAL,
        ST_WRITE,
        ST_MREQ,
        ST_MCAP,
        ST_RD,
        ST_CHK,
        ST_DIV,
        ST_EMIT,
        ST_FLUSH
    } state_t;

endpackage

### rtl/core/landmark_weighted_average_table.sv
// Channel   Dir  Handshake             Word
// s_        in   s_valid / s_ready     in_t: one marker sighting with robot pose
// m_        out  m_valid / m_ready     out_t: averaged position of one marker id
// cfg_      in   cfg_we (no wait)      threshold and history length
//
// A dropped sighting is discarded. A kept one goes through the pose multiply,
// the 16 CORDIC steps (cut short for a degenerate quaternion) and the history
// write, then the scan of every id: an empty id ends after its metadata read,
// one with entries and a zero confidence sum after its history reads, and an
// emitted id takes one history read per entry and the shared-step dividers.
// Reset restores the register defaults and marks every id empty via per-id
// valid flags; no clearing pass. A new sighting is taken once the scan is done;
// a stalled output holds one result in the output word, one pending behind it.
module landmark_weighted_average_table
    import lwat_pkg::*;
#(
    parameter int NUM_IDS       = NUM_IDS_DEF,
    parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_addr,
    input  logic [CFG_W-1:0]     cfg_wdata,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  in_t                  s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output out_t                 m_data
);

    localparam int ID_W    = $clog2(NUM_IDS);
    localparam int SLOT_W  = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int HIST_N  = NUM_IDS * HISTORY_DEPTH;
    localparam int HADDR_W = $clog2(HIST_N);
    localparam int CNT_W   = 5;
    localparam int LIM_MAX = (HISTORY_DEPTH < 31) ? HISTORY_DEPTH : 31;
    localparam int CW      = 36;
    localparam int UW      = 38;
    localparam int PW      = UW + 17;
    localparam int SC_W    = 16 + $clog2(HISTORY_DEPTH + 1);
    localparam int ACC_W   = SC_W + 24;
    localparam int N_W     = ACC_W + 1;
    localparam int D_W     = SC_W + 1;
    localparam int Q_W     = 25;
    localparam int DC_W    = $clog2(Q_W);
    localparam int LANES   = 4;
    localparam int STEP_W  = $clog2(CORDIC_STEPS);

    localparam logic signed [CW-1:0] D_BIAS = CW'(2**30);
    localparam logic signed [PW-1:0] RND    = PW'(2**29);

    typedef struct packed {
        logic [CNT_W-1:0]  count;
        logic [SLOT_W-1:0] slot;
    } meta_t;

    typedef struct packed {
        logic signed [23:0] x;
        logic signed [23:0] y;
        logic signed [23:0] z;
        logic        [15:0] conf;
    } hist_t;

    function automatic logic signed [23:0] sat24(input logic signed [25:0] v);
        if (v > 26'sd8388607) begin
            return 24'sh7FFFFF;
        end else if (v < -26'sd8388608) begin
            return 24'sh800000;
        end else begin
            return v[23:0];
        end
    endfunction

    function automatic logic [SLOT_W-1:0] slot_dec(input logic [SLOT_W-1:0] s);
        return (s == '0) ? SLOT_W'(HISTORY_DEPTH - 1) : s - 1'b1;
    endfunction

    function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s);
        return (s == SLOT_W'(HISTORY_DEPTH - 1)) ? '0 : s + 1'b1;
    endfunction

    state_t state_reg, state_next;

    logic [15:0]      thr_reg;
    logic [4:0]       mo_reg;
    in_t              in_reg;

    logic signed [31:0]   p_wz_reg, p_xy_reg, p_yy_reg, p_zz_reg;
    logic signed [CW-1:0] d_reg, n_reg;
    logic signed [UW-1:0] u_reg, v_reg;
    logic                 degen_reg;
    logic [STEP_W-1:0]    i_reg;
    logic signed [PW-1:0] pu_reg, pv_reg;
    hist_t                g_reg;

    meta_t              meta_mem [NUM_IDS];
    meta_t              meta_q_reg;
    logic               meta_qv_reg;
    logic [NUM_IDS-1:0] meta_vld_reg;
    hist_t              hist_mem [HIST_N];
    hist_t              hist_q_reg;

    logic [ID_W-1:0]    k_reg;
    logic [HADDR_W-1:0] base_reg;
    logic [SLOT_W-1:0]  ptr_reg;
    logic [CNT_W-1:0]   left_reg, cnt_reg;
    logic               v1_reg, v2_reg;
    logic signed [40:0] prx_reg, pry_reg, prz_reg;
    logic [15:0]        prc_reg;
    logic signed [ACC_W-1:0] sx_reg, sy_reg, sz_reg;
    logic [SC_W-1:0]    sc_reg;

    logic [D_W-1:0]  rem_reg [LANES];
    logic [Q_W-1:0]  nlo_reg [LANES];
    logic [Q_W-1:0]  quo_reg [LANES];
    logic [D_W-1:0]  dvs_reg [LANES];
    logic [2:0]      neg_reg;
    logic [DC_W-1:0] dcnt_reg;

    out_t pend_reg, out_reg;
    logic pend_vld_reg, m_valid_reg;

    // control strobes
    logic              accept, keep, out_free, last_k, adv_id;
    logic              meta_ren, hist_ren, out_load, out_last;
    logic [ID_W-1:0]   meta_raddr;
    logic [CNT_W-1:0]  mcap_cnt;
    logic [SLOT_W-1:0] mcap_slot;
    logic [CNT_W-1:0]  lim, new_cnt;
    logic [CNT_W:0]    cnt_inc;
    logic [HADDR_W-1:0] hist_waddr, hist_raddr;

    assign s_ready   = (state_reg == ST_IDLE);
    assign accept    = s_valid && s_ready;
    assign keep      = (s_data.sighting_confidence >= thr_reg) &&
                       (7'(s_data.marker_id) < 7'(NUM_IDS));
    assign out_free  = !m_valid_reg || m_ready;
    assign last_k    = (k_reg == ID_W'(NUM_IDS - 1));
    // an id never written reads as empty with slot zero
    assign mcap_cnt  = meta_qv_reg ? meta_q_reg.count : '0;
    assign mcap_slot = meta_qv_reg ? meta_q_reg.slot : '0;
    assign m_valid   = m_valid_reg;
    assign m_data    = out_reg;

    // next state and strobes
    always_comb begin
        state_next = state_reg;
        meta_ren   = 1'b0;
        meta_raddr = k_reg;
        hist_ren   = 1'b0;
        adv_id     = 1'b0;
        out_load   = 1'b0;
        out_last   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept && keep) state_next = ST_MUL;
            end
            ST_MUL: state_next = ST_PREP;
            ST_PREP: state_next = ST_ROT;
            ST_ROT: begin
                if (degen_reg || i_reg == STEP_W'(CORDIC_STEPS - 1)) state_next = ST_SCALE;
            end
            ST_SCALE: begin
                meta_ren   = 1'b1;
                meta_raddr = in_reg.marker_id[ID_W-1:0];
                state_next = ST_GLOBAL;
            end
            ST_GLOBAL: state_next = ST_WRITE;
            ST_WRITE: state_next = ST_MREQ;
            ST_MREQ: begin
                meta_ren   = 1'b1;
                state_next = ST_MCAP;
            end
            ST_MCAP: begin
                if (mcap_cnt == '0) begin
                    adv_id     = 1'b1;
                    state_next = last_k ? ST_FLUSH : ST_MREQ;
                end else begin
                    state_next = ST_RD;
                end
            end
            ST_RD: begin
                hist_ren = (left_reg != '0);
                if (left_reg == '0 && !v1_reg && !v2_reg) state_next = ST_CHK;
            end
            ST_CHK: begin
                if (sc_reg == '0) begin
                    adv_id     = 1'b1;
                    state_next = last_k ? ST_FLUSH : ST_MREQ;
                end else begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                if (dcnt_reg == DC_W'(Q_W - 1)) state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (!pend_vld_reg || out_free) begin
                    out_load   = pend_vld_reg;
                    adv_id     = 1'b1;
                    state_next = last_k ? ST_FLUSH : ST_MREQ;
                end
            end
            ST_FLUSH: begin
                out_last = 1'b1;
                if (!pend_vld_reg) begin
                    state_next = ST_IDLE;
                end else if (out_free) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // history limit and count update
    always_comb begin
        if (mo_reg == '0) begin
            lim = CNT_W'(1);
        end else if (6'(mo_reg) > 6'(LIM_MAX)) begin
            lim = CNT_W'(LIM_MAX);
        end else begin
            lim = mo_reg;
        end
        cnt_inc = (CNT_W+1)'(mcap_cnt) + 1'b1;
        new_cnt = (cnt_inc > (CNT_W+1)'(lim)) ? lim : cnt_inc[CNT_W-1:0];
    end

    assign hist_waddr = HADDR_W'(int'(in_reg.marker_id[ID_W-1:0]) * HISTORY_DEPTH)
                      + HADDR_W'(mcap_slot);
    assign hist_raddr = base_reg + HADDR_W'(ptr_reg);

    // yaw terms and pre-rotation into the right half plane
    logic signed [CW-1:0] prep_n, prep_d, pre_d, pre_n;
    logic signed [UW-1:0] prep_u, prep_v, pre_u, pre_v;
    always_comb begin
        prep_n = (CW'(p_wz_reg) + CW'(p_xy_reg)) <<< 1;
        prep_d = D_BIAS - ((CW'(p_yy_reg) + CW'(p_zz_reg)) <<< 1);
        prep_u = UW'(in_reg.cam_away) <<< 14;
        prep_v = -(UW'(in_reg.cam_right) <<< 14);
        pre_d  = prep_d;
        pre_n  = prep_n;
        pre_u  = prep_u;
        pre_v  = prep_v;
        if (prep_d < 0) begin
            if (prep_n >= 0) begin
                pre_d = prep_n;
                pre_n = -prep_d;
                pre_u = -prep_v;
                pre_v = prep_u;
            end else begin
                pre_d = -prep_n;
                pre_n = prep_d;
                pre_u = prep_v;
                pre_v = -prep_u;
            end
        end
    end

    // one CORDIC step
    logic signed [CW-1:0] rot_d, rot_n;
    logic signed [UW-1:0] rot_u, rot_v;
    always_comb begin
        if (n_reg >= 0) begin
            rot_d = d_reg + (n_reg >>> i_reg);
            rot_n = n_reg - (d_reg >>> i_reg);
            rot_u = u_reg - (v_reg >>> i_reg);
            rot_v = v_reg + (u_reg >>> i_reg);
        end else begin
            rot_d = d_reg - (n_reg >>> i_reg);
            rot_n = n_reg + (d_reg >>> i_reg);
            rot_u = u_reg + (v_reg >>> i_reg);
            rot_v = v_reg - (u_reg >>> i_reg);
        end
    end

    // world point
    hist_t                g_next;
    logic signed [PW-1:0] ru_full, rv_full;
    logic signed [25:0]   gx_sum, gy_sum, gz_sum;
    always_comb begin
        ru_full = (pu_reg + RND) >>> 30;
        rv_full = (pv_reg + RND) >>> 30;
        if (degen_reg) begin
            gx_sum = 26'(in_reg.robot_x) + 26'(in_reg.cam_away);
            gy_sum = 26'(in_reg.robot_y) - 26'(in_reg.cam_right);
        end else begin
            gx_sum = 26'(in_reg.robot_x) + 26'(ru_full);
            gy_sum = 26'(in_reg.robot_y) + 26'(rv_full);
        end
        gz_sum      = 26'(in_reg.robot_z) + 26'(in_reg.cam_up);
        g_next.x    = sat24(gx_sum);
        g_next.y    = sat24(gy_sum);
        g_next.z    = sat24(gz_sum);
        g_next.conf = in_reg.sighting_confidence;
    end

    // divider operands: three rounded means and the mean confidence
    logic [N_W-1:0]   div_n [LANES];
    logic [D_W-1:0]   div_d [LANES];
    logic [ACC_W-1:0] mag_x, mag_y, mag_z;
    always_comb begin
        mag_x    = sx_reg[ACC_W-1] ? ACC_W'(-sx_reg) : ACC_W'(sx_reg);
        mag_y    = sy_reg[ACC_W-1] ? ACC_W'(-sy_reg) : ACC_W'(sy_reg);
        mag_z    = sz_reg[ACC_W-1] ? ACC_W'(-sz_reg) : ACC_W'(sz_reg);
        div_n[0] = {mag_x, 1'b0} + N_W'(sc_reg);
        div_n[1] = {mag_y, 1'b0} + N_W'(sc_reg);
        div_n[2] = {mag_z, 1'b0} + N_W'(sc_reg);
        div_n[3] = N_W'({sc_reg, 1'b0}) + N_W'(cnt_reg);
        div_d[0] = {sc_reg, 1'b0};
        div_d[1] = {sc_reg, 1'b0};
        div_d[2] = {sc_reg, 1'b0};
        div_d[3] = D_W'({cnt_reg, 1'b0});
    end

    // one restoring step per lane
    logic [D_W-1:0] rem_next [LANES];
    logic           qbit     [LANES];
    logic [D_W:0]   trial    [LANES];
    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            trial[l] = {rem_reg[l], nlo_reg[l][Q_W-1]};
            qbit[l]  = (trial[l] >= {1'b0, dvs_reg[l]});
            rem_next[l] = qbit[l] ? D_W'(trial[l] - {1'b0, dvs_reg[l]}) : D_W'(trial[l]);
        end
    end

    // result word
    out_t               res;
    logic signed [25:0] qs   [3];
    logic signed [25:0] qval [3];
    always_comb begin
        for (int l = 0; l < 3; l++) begin
            qs[l]   = $signed({1'b0, quo_reg[l]});
            qval[l] = neg_reg[l] ? -qs[l] : qs[l];
        end
        res.out_id          = 6'(k_reg);
        res.mean_x          = sat24(qval[0]);
        res.mean_y          = sat24(qval[1]);
        res.mean_z          = sat24(qval[2]);
        res.mean_confidence = quo_reg[3][15:0];
        res.obs_count       = cnt_reg;
        res.last_result     = 1'b0;
    end

    // pending word with the final flag applied
    out_t out_word;
    always_comb begin
        out_word             = pend_reg;
        out_word.last_result = out_last;
    end

    // metadata memory with per-id valid flags
    always_ff @(posedge aclk) begin
        if (state_reg == ST_WRITE) begin
            meta_mem[in_reg.marker_id[ID_W-1:0]] <= '{count: new_cnt,
                                                     slot: slot_inc(mcap_slot)};
        end
        if (meta_ren) begin
            meta_q_reg  <= meta_mem[meta_raddr];
            meta_qv_reg <= meta_vld_reg[meta_raddr];
        end
    end

    // history memory
    always_ff @(posedge aclk) begin
        if (state_reg == ST_WRITE) begin
            hist_mem[hist_waddr] <= g_reg;
        end
        if (hist_ren) begin
            hist_q_reg <= hist_mem[hist_raddr];
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            thr_reg      <= THRESHOLD_RST;
            mo_reg       <= MAX_OBS_RST;
            meta_vld_reg <= '0;
            pend_vld_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            v1_reg       <= 1'b0;
            v2_reg       <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_we) begin
                unique case (cfg_idx_t'(cfg_addr))
                    CFG_THRESHOLD: thr_reg <= cfg_wdata;
                    CFG_MAX_OBS:   mo_reg  <= cfg_wdata[4:0];
                    default: ;
                endcase
            end
            if (state_reg == ST_WRITE) begin
                meta_vld_reg[in_reg.marker_id[ID_W-1:0]] <= 1'b1;
            end
            v1_reg <= hist_ren;
            v2_reg <= v1_reg;
            if (state_reg == ST_EMIT && adv_id) begin
                pend_vld_reg <= 1'b1;
            end else if (state_reg == ST_FLUSH && out_load) begin
                pend_vld_reg <= 1'b0;
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        if (accept) in_reg <= s_data;

        // pose products and CORDIC
        if (state_reg == ST_MUL) begin
            p_wz_reg <= 32'(in_reg.quat_w) * 32'(in_reg.quat_z);
            p_xy_reg <= 32'(in_reg.quat_x) * 32'(in_reg.quat_y);
            p_yy_reg <= 32'(in_reg.quat_y) * 32'(in_reg.quat_y);
            p_zz_reg <= 32'(in_reg.quat_z) * 32'(in_reg.quat_z);
        end
        if (state_reg == ST_PREP) begin
            degen_reg <= (prep_n == 0) && (prep_d == 0);
            d_reg     <= pre_d;
            n_reg     <= pre_n;
            u_reg     <= pre_u;
            v_reg     <= pre_v;
            i_reg     <= '0;
        end
        if (state_reg == ST_ROT) begin
            d_reg <= rot_d;
            n_reg <= rot_n;
            u_reg <= rot_u;
            v_reg <= rot_v;
            i_reg <= i_reg + 1'b1;
        end
        if (state_reg == ST_SCALE) begin
            pu_reg <= PW'(u_reg) * PW'($signed(INV_GAIN));
            pv_reg <= PW'(v_reg) * PW'($signed(INV_GAIN));
        end
        if (state_reg == ST_GLOBAL) g_reg <= g_next;

        // scan walk over ids
        if (state_reg == ST_WRITE) begin
            k_reg    <= '0;
            base_reg <= '0;
        end
        if (adv_id) begin
            k_reg    <= k_reg + 1'b1;
            base_reg <= base_reg + HADDR_W'(HISTORY_DEPTH);
        end
        if (state_reg == ST_MCAP && mcap_cnt != '0) begin
            cnt_reg  <= mcap_cnt;
            left_reg <= mcap_cnt;
            ptr_reg  <= slot_dec(mcap_slot);
            sx_reg   <= '0;
            sy_reg   <= '0;
            sz_reg   <= '0;
            sc_reg   <= '0;
        end
        if (hist_ren) begin
            ptr_reg  <= slot_dec(ptr_reg);
            left_reg <= left_reg - 1'b1;
        end

        // weight and accumulate
        if (v1_reg) begin
            prx_reg <= 41'(hist_q_reg.x) * 41'($signed({1'b0, hist_q_reg.conf}));
            pry_reg <= 41'(hist_q_reg.y) * 41'($signed({1'b0, hist_q_reg.conf}));
            prz_reg <= 41'(hist_q_reg.z) * 41'($signed({1'b0, hist_q_reg.conf}));
            prc_reg <= hist_q_reg.conf;
        end
        if (v2_reg) begin
            sx_reg <= sx_reg + ACC_W'(prx_reg);
            sy_reg <= sy_reg + ACC_W'(pry_reg);
            sz_reg <= sz_reg + ACC_W'(prz_reg);
            sc_reg <= sc_reg + SC_W'(prc_reg);
        end

        // dividers
        if (state_reg == ST_CHK) begin
            for (int l = 0; l < LANES; l++) begin
                rem_reg[l] <= D_W'(div_n[l] >> Q_W);
                nlo_reg[l] <= div_n[l][Q_W-1:0];
                quo_reg[l] <= '0;
                dvs_reg[l] <= div_d[l];
            end
            neg_reg  <= {sz_reg[ACC_W-1], sy_reg[ACC_W-1], sx_reg[ACC_W-1]};
            dcnt_reg <= '0;
        end
        if (state_reg == ST_DIV) begin
            for (int l = 0; l < LANES; l++) begin
                rem_reg[l] <= rem_next[l];
                nlo_reg[l] <= nlo_reg[l] << 1;
                quo_reg[l] <= {quo_reg[l][Q_W-2:0], qbit[l]};
            end
            dcnt_reg <= dcnt_reg + 1'b1;
        end

        // pending and output words
        if (state_reg == ST_EMIT && adv_id) pend_reg <= res;
        if (out_load) out_reg <= out_word;
    end

endmodule
